>>> rtl/scla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scla_pkg
// Shared codes, command and status types of the serial command line assembler.
// ----------------------------------------------------------------------------
package scla_pkg;

   localparam int unsigned BYTE_W = 8;

   // ascii control codes that edit the line
   localparam logic [BYTE_W-1:0] CH_SOH = 8'h01;
   localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
   localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;
   localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
   localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_ETB = 8'h17;
   localparam logic [BYTE_W-1:0] CH_ESC = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;

   // request command codes
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // edit buffer operations
   typedef enum logic [2:0] {
      ED_NONE,
      ED_STORE,
      ED_BACK,
      ED_RESTART,
      ED_RESTART_STORE,
      ED_TERM
   } ed_op_type;

   // controller to datapath commands
   typedef struct packed {
      ed_op_type ed_op;
      logic      copy_rd;
      logic      copy_end;
      logic      line_rd;
      logic      ring_pop;
      logic      rsp_load_line;
      logic      rsp_load_empty;
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic ring_empty;
      logic cnt_last;
      logic rd_last;
      logic out_free;
   } dp_stat_type;

endpackage : scla_pkg
`default_nettype wire

>>> rtl/scla_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scla_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface scla_req_if
   import scla_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [BYTE_W-1:0] char_in;

   modport source (output valid, output cmd, output char_in, input ready);
   modport sink   (input valid, input cmd, input char_in, output ready);
endinterface : scla_req_if

interface scla_rsp_if
   import scla_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] line_byte;
   logic              last;
   logic              empty_res;

   modport source (output valid, output line_byte, output last, output empty_res,
                   input ready);
   modport sink   (input valid, input line_byte, input last, input empty_res,
                   output ready);
endinterface : scla_rsp_if
`default_nettype wire

>>> rtl/scla_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scla_ctrl
// Sequencer: decodes request words, runs the line copy and the line readout.
// ----------------------------------------------------------------------------
module scla_ctrl
   import scla_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_cmd,
   input  wire logic [BYTE_W-1:0] req_char_in,
   output logic                   req_ready,
   input  wire dp_stat_type       stat,
   output ctl_cmd_type            cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TERM,
      ST_COPY,
      ST_COPY_END,
      ST_RD_LOAD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // a read request needs a free output register, characters do not
   assign req_ready = (state_ff == ST_IDLE) && (stat.out_free || (req_cmd == CMD_CHAR));
   assign accept    = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '{ed_op: ED_NONE, default: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_CHAR) begin
                  unique case (req_char_in)
                     CH_ETB: begin
                        cmd.ed_op = ED_STORE;
                        state_in  = ST_TERM;
                     end
                     CH_CR, CH_ETX: begin
                        cmd.ed_op = ED_TERM;
                        state_in  = ST_COPY;
                     end
                     CH_BS, CH_DEL:         cmd.ed_op = ED_BACK;
                     CH_LF, CH_ESC, CH_STX: cmd.ed_op = ED_RESTART;
                     CH_SOH:                cmd.ed_op = ED_RESTART_STORE;
                     default:               cmd.ed_op = ED_STORE;
                  endcase
               end else if (stat.ring_empty) begin
                  cmd.rsp_load_empty = 1'b1;
               end else begin
                  cmd.line_rd = 1'b1;
                  state_in    = ST_RD_LOAD;
               end
            end
         end
         ST_TERM: begin
            cmd.ed_op = ED_TERM;
            state_in  = ST_COPY;
         end
         ST_COPY: begin
            cmd.copy_rd = 1'b1;
            if (stat.cnt_last) begin
               state_in = ST_COPY_END;
            end
         end
         ST_COPY_END: begin
            cmd.copy_end = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_RD_LOAD: begin
            if (stat.out_free) begin
               cmd.rsp_load_line = 1'b1;
               if (stat.rd_last) begin
                  cmd.ring_pop = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  cmd.line_rd = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : scla_ctrl
`default_nettype wire

>>> rtl/scla_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scla_dpath
// Edit buffer, ring of line slots, byte counter and response register.
// ----------------------------------------------------------------------------
module scla_dpath
   import scla_pkg::*;
#(
   parameter int unsigned LINE_LEN   = 64,
   parameter int unsigned LINE_COUNT = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [BYTE_W-1:0] req_char_in,
   input  wire ctl_cmd_type       cmd,
   output dp_stat_type            stat,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [BYTE_W-1:0]      rsp_line_byte,
   output logic                   rsp_last,
   output logic                   rsp_empty_res
);

   localparam int unsigned PW    = $clog2(LINE_LEN);
   localparam int unsigned SW    = $clog2(LINE_COUNT);
   localparam int unsigned DEPTH = LINE_COUNT * (2 ** PW);
   localparam logic [PW-1:0] POS_LAST  = PW'(LINE_LEN - 1);
   localparam logic [SW-1:0] SLOT_LAST = SW'(LINE_COUNT - 1);

   // storage
   logic [BYTE_W-1:0] edit_mem [LINE_LEN];
   logic [BYTE_W-1:0] line_mem [DEPTH];

   // edit state
   logic [LINE_LEN-1:0] valid_ff, valid_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic                edit_we;
   logic [PW-1:0]       edit_waddr;

   // ring and counter
   logic [SW-1:0] wslot_ff, rslot_ff;
   logic [PW-1:0] cnt_ff;
   logic          cnt_last;

   // copy pipeline
   logic              cpy_we_ff;
   logic [PW-1:0]     cpy_idx_ff;
   logic [BYTE_W-1:0] edt_q_ff;
   logic              edt_v_ff;

   // readout pipeline
   logic [BYTE_W-1:0] line_q_ff;
   logic              line_last_ff;

   // response register
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;
   logic              rsp_empty_ff;
   logic              out_free;

   assign cnt_last = (cnt_ff == POS_LAST);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign stat.ring_empty = (rslot_ff == wslot_ff);
   assign stat.cnt_last   = cnt_last;
   assign stat.rd_last    = line_last_ff;
   assign stat.out_free   = out_free;

   // edit position and valid bits; an entry without its valid bit reads as zero
   always_comb begin
      pos_in     = pos_ff;
      valid_in   = valid_ff;
      edit_we    = 1'b0;
      edit_waddr = pos_ff;
      unique case (cmd.ed_op)
         ED_NONE: ;
         ED_STORE: begin
            if (pos_ff != POS_LAST) begin
               edit_we          = 1'b1;
               valid_in[pos_ff] = 1'b1;
               pos_in           = pos_ff + PW'(1);
            end
         end
         ED_BACK: begin
            if (pos_ff != '0) begin
               pos_in = pos_ff - PW'(1);
            end
         end
         ED_RESTART: pos_in = '0;
         ED_RESTART_STORE: begin
            edit_we     = 1'b1;
            edit_waddr  = '0;
            valid_in[0] = 1'b1;
            pos_in      = PW'(1);
         end
         ED_TERM: valid_in[pos_ff] = 1'b0;
      endcase
      if (cmd.copy_end) begin
         valid_in = '0;
         pos_in   = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         pos_ff       <= '0;
         wslot_ff     <= '0;
         rslot_ff     <= '0;
         cnt_ff       <= '0;
         cpy_we_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         pos_ff    <= pos_in;
         cpy_we_ff <= cmd.copy_rd;
         if (cmd.copy_end) begin
            wslot_ff <= (wslot_ff == SLOT_LAST) ? '0 : wslot_ff + SW'(1);
         end
         if (cmd.ring_pop) begin
            rslot_ff <= (rslot_ff == SLOT_LAST) ? '0 : rslot_ff + SW'(1);
         end
         if (cmd.copy_rd || cmd.line_rd) begin
            cnt_ff <= cnt_last ? '0 : cnt_ff + PW'(1);
         end
         if (cmd.rsp_load_line || cmd.rsp_load_empty) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // edit buffer memory
   always_ff @(posedge clock) begin
      if (edit_we) begin
         edit_mem[edit_waddr] <= req_char_in;
      end
      if (cmd.copy_rd) begin
         edt_q_ff   <= edit_mem[cnt_ff];
         edt_v_ff   <= valid_ff[cnt_ff];
         cpy_idx_ff <= cnt_ff;
      end
   end

   // line slot memory
   always_ff @(posedge clock) begin
      if (cpy_we_ff) begin
         line_mem[{wslot_ff, cpy_idx_ff}] <= edt_v_ff ? edt_q_ff : '0;
      end
      if (cmd.line_rd) begin
         line_q_ff    <= line_mem[{rslot_ff, cnt_ff}];
         line_last_ff <= cnt_last;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.rsp_load_empty) begin
         rsp_byte_ff  <= '0;
         rsp_last_ff  <= 1'b1;
         rsp_empty_ff <= 1'b1;
      end else if (cmd.rsp_load_line) begin
         rsp_byte_ff  <= line_q_ff;
         rsp_last_ff  <= line_last_ff;
         rsp_empty_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_line_byte = rsp_byte_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;

`ifndef SYNTHESIS
   // the edit line is reset after every copy
   a_copy_end_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_end |=> (pos_ff == '0) && (valid_ff == '0))
      else $error("edit line not cleared after copy");

   // a line is only read out while one is waiting
   a_read_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.line_rd |-> !stat.ring_empty)
      else $error("line read from an empty ring");

   // the response register is never overwritten while full
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load_line || cmd.rsp_load_empty) |-> out_free)
      else $error("response word overwritten");

   // an empty response is a single zero word
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_last_ff && (rsp_byte_ff == '0)))
      else $error("malformed empty response");

   // copy and readout never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_rd |-> (!cmd.line_rd && (cmd.ed_op == ED_NONE)))
      else $error("copy overlaps another operation");
`endif

endmodule : scla_dpath
`default_nettype wire

>>> rtl/serial_command_line_assembler.sv
`default_nettype none
// A line-completing character (CR, ETX) holds the input through the copy
// states and ETB also through a terminate state before them, while the edit
// buffer is copied into a ring slot one byte per cycle through the single read
// port of the edit buffer memory. A read word returns LINE_LEN response words
// at one per cycle when the sink keeps ready high, set by the one read port of
// the line slot memory; an empty ring gives one word flagged empty. A read
// word is accepted only when the response register is free or being emptied;
// character words are accepted while a response still waits.
// ----------------------------------------------------------------------------
// serial_command_line_assembler
// Builds command lines from serial characters and keeps a ring of finished
// lines that are read out byte by byte.
// ----------------------------------------------------------------------------
module serial_command_line_assembler
   import scla_pkg::*;
#(
   parameter int unsigned LINE_LEN   = 64,
   parameter int unsigned LINE_COUNT = 8
) (
   input wire logic    clock,
   input wire logic    reset,
   scla_req_if.sink    req_ch,
   scla_rsp_if.source  rsp_ch
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // sequencer
   scla_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_cmd     (req_ch.cmd),
      .req_char_in (req_ch.char_in),
      .req_ready   (req_ch.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   // storage and response register
   scla_dpath #(
      .LINE_LEN   (LINE_LEN),
      .LINE_COUNT (LINE_COUNT)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_char_in   (req_ch.char_in),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_line_byte (rsp_ch.line_byte),
      .rsp_last      (rsp_ch.last),
      .rsp_empty_res (rsp_ch.empty_res)
   );

endmodule : serial_command_line_assembler
`default_nettype wire

>>> dv/scla_readout_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scla_readout_check
// Watches the request and response channels of the line assembler, keeps its
// own edit buffer and ring of finished lines, and checks every response word
// in order against the words that the accepted requests call for.
// ----------------------------------------------------------------------------
module scla_readout_check
   import scla_pkg::*;
#(
   parameter int unsigned LINE_LEN   = 64,
   parameter int unsigned LINE_COUNT = 8
) (
   input wire logic clock,
   input wire logic reset,
   scla_req_if      req_ch,
   scla_rsp_if      rsp_ch,
   output int       mismatch_count,
   output int       words_due
);

   typedef struct packed {
      logic [BYTE_W-1:0] line_byte;
      logic              last;
      logic              empty_res;
   } line_word_type;

   // line being edited and the ring of finished lines
   logic [BYTE_W-1:0] edit_line [LINE_LEN];
   logic [BYTE_W-1:0] line_slots [LINE_COUNT][LINE_LEN];
   int unsigned       edit_pos;
   int unsigned       fill_slot;
   int unsigned       out_slot;

   // response words still owed by the block, oldest first
   line_word_type     owed_words [$];

   // characters past the last free position are dropped
   function automatic void keep_char(input logic [BYTE_W-1:0] ch);
      if (edit_pos < LINE_LEN - 1) begin
         edit_line[edit_pos] = ch;
         edit_pos++;
      end
   endfunction

   // terminate, copy into the ring, clear the edit buffer
   function automatic void close_line();
      edit_line[edit_pos] = '0;
      foreach (edit_line[i]) begin
         line_slots[fill_slot][i] = edit_line[i];
         edit_line[i] = '0;
      end
      edit_pos  = 0;
      fill_slot = (fill_slot + 1) % LINE_COUNT;
   endfunction

   // apply one request word, queue the response words it causes
   function automatic void absorb_word(input logic cmd, input logic [BYTE_W-1:0] ch);
      line_word_type w;
      if (cmd == CMD_CHAR) begin
         case (ch)
            CH_ETB: begin
               keep_char(ch);
               close_line();
            end
            CH_CR, CH_ETX: close_line();
            CH_BS, CH_DEL: if (edit_pos > 0) edit_pos--;
            CH_LF, CH_ESC, CH_STX: edit_pos = 0;
            CH_SOH: begin
               edit_pos = 0;
               keep_char(ch);
            end
            default: keep_char(ch);
         endcase
      end else if (out_slot == fill_slot) begin
         // nothing waiting (also after the ring has been overrun)
         w.line_byte = '0;
         w.last      = 1'b1;
         w.empty_res = 1'b1;
         owed_words.push_back(w);
      end else begin
         for (int i = 0; i < LINE_LEN; i++) begin
            w.line_byte = line_slots[out_slot][i];
            w.last      = (i == LINE_LEN - 1);
            w.empty_res = 1'b0;
            owed_words.push_back(w);
         end
         out_slot = (out_slot + 1) % LINE_COUNT;
      end
   endfunction

   always @(posedge clock) begin : watch
      line_word_type want;
      if (reset) begin
         foreach (edit_line[i]) edit_line[i] = '0;
         foreach (line_slots[s, i]) line_slots[s][i] = '0;
         edit_pos       = 0;
         fill_slot      = 0;
         out_slot       = 0;
         mismatch_count = 0;
         owed_words.delete();
      end else begin
         // response side first, so a stray word never meets a fresh expectation
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (owed_words.size() == 0) begin
               $error("unexpected word: line_byte %02h last %0b empty_res %0b",
                      rsp_ch.line_byte, rsp_ch.last, rsp_ch.empty_res);
               mismatch_count++;
            end else begin
               want = owed_words.pop_front();
               if (rsp_ch.line_byte !== want.line_byte) begin
                  $error("line_byte: expected %02h, got %02h",
                         want.line_byte, rsp_ch.line_byte);
                  mismatch_count++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
                  mismatch_count++;
               end
               if (rsp_ch.empty_res !== want.empty_res) begin
                  $error("empty_res: expected %0b, got %0b",
                         want.empty_res, rsp_ch.empty_res);
                  mismatch_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            absorb_word(req_ch.cmd, req_ch.char_in);
      end
      words_due <= owed_words.size();
   end

endmodule : scla_readout_check

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives character and read words into the line assembler under changing
// sender gaps and receiver stalls, with a long receiver hold-off and a full
// drain, and reports the result of the response check.
// ----------------------------------------------------------------------------
module testbench;
   import scla_pkg::*;

   localparam int unsigned LINE_LEN     = 64;
   localparam int unsigned LINE_COUNT   = 8;
   localparam int unsigned RANDOM_WORDS = 200;
   localparam int unsigned LONG_HOLD    = 400;
   localparam int unsigned HALF_PERIOD  = 5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_done = 0;
   int unsigned words_sent = 0;
   int          mismatch_count;
   int          words_due;

   logic [BYTE_W-1:0] line_ends [3]     = '{CH_CR, CH_ETX, CH_ETB};
   logic [BYTE_W-1:0] line_restarts [4] = '{CH_LF, CH_ESC, CH_STX, CH_SOH};

   scla_req_if req_ch ();
   scla_rsp_if rsp_ch ();

   serial_command_line_assembler #(
      .LINE_LEN   (LINE_LEN),
      .LINE_COUNT (LINE_COUNT)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   scla_readout_check #(
      .LINE_LEN   (LINE_LEN),
      .LINE_COUNT (LINE_COUNT)
   ) readout_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // hard stop for a hung run
   initial begin
      #(5_000_000);
      $display("Some tests failed");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when one is requested
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // offer one word after a random gap, return at the edge it is taken
   task automatic send_word(input logic cmd, input logic [BYTE_W-1:0] ch);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.cmd     <= cmd;
      req_ch.char_in <= ch;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_char(input logic [BYTE_W-1:0] ch);
      send_word(CMD_CHAR, ch);
   endtask

   task automatic send_read();
      send_word(CMD_READ, BYTE_W'($urandom_range(255)));
   endtask

   // mostly printable text with some edits, closed by the given code
   task automatic send_line(input int unsigned n, input logic [BYTE_W-1:0] closer);
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(99) < 8)
            send_char($urandom_range(1) ? CH_BS : CH_DEL);
         else if ($urandom_range(99) < 85)
            send_char(BYTE_W'($urandom_range(8'h7E, 8'h20)));
         else
            send_char(BYTE_W'($urandom_range(255)));
      end
      send_char(closer);
   endtask

   // hold the input idle until every owed response word has arrived
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
   endtask

   task automatic random_sequence();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(99);
      if (pick < 60) begin
         // well-formed line, now and then past the line length
         n = ($urandom_range(99) < 6) ? $urandom_range(70, 58) : $urandom_range(12);
         send_line(n, line_ends[$urandom_range(2)]);
         if ($urandom_range(99) < 40) send_read();
      end else if (pick < 78) begin
         repeat ($urandom_range(3, 1)) send_read();
      end else if (pick < 90) begin
         // raw byte noise
         repeat ($urandom_range(5, 1)) send_char(BYTE_W'($urandom_range(255)));
      end else begin
         // line cut short by a restart code and left open
         send_line($urandom_range(6), line_restarts[$urandom_range(3)]);
      end
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.cmd     = CMD_CHAR;
      req_ch.char_in = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty read, backspace at start, stale byte after terminator
      send_read();
      send_char(CH_BS);
      send_char(8'h41);
      send_char(8'hFF);
      send_char(8'h00);
      send_char(8'h55);
      send_char(CH_DEL);
      send_char(CH_BS);
      send_char(CH_CR);
      // stored start code, end of text
      send_char(CH_SOH);
      send_char(8'h7E);
      send_char(CH_ETX);
      // each restart code, then a stored end of block
      send_char(8'h71);
      send_char(CH_LF);
      send_char(8'h72);
      send_char(CH_ESC);
      send_char(8'h73);
      send_char(CH_STX);
      send_char(8'h74);
      send_char(CH_ETB);
      repeat (4) send_read();

      // random part in four idling phases
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
               // line overflow
               send_line(70, CH_CR);
               send_read();
            end
            1: begin
               idle_pct  = 57;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 57;
               // long receiver hold-off while reads pile up
               hold_requests++;
               repeat (3) send_line($urandom_range(10, 1), line_ends[$urandom_range(2)]);
               repeat (4) send_read();
            end
            default: begin
               idle_pct  = 26;
               stall_pct = 26;
               // ring overrun: more lines than slots, then reads
               repeat (LINE_COUNT + 1) send_line($urandom_range(3), CH_CR);
               repeat (3) send_read();
            end
         endcase
         while (words_sent < 24 + (phase + 1) * RANDOM_WORDS / 4) random_sequence();
         if (phase == 1) wait_for_results();
      end

      wait_for_results();
      repeat (4 * LINE_LEN) @(posedge clock);
      if (mismatch_count == 0 && words_due == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule : testbench

>>> serial_command_line_assembler.f
rtl/scla_pkg.sv
rtl/scla_if.sv
rtl/scla_ctrl.sv
rtl/scla_dpath.sv
rtl/serial_command_line_assembler.sv
dv/scla_readout_check.sv
dv/testbench.sv
